### hw/rtl/length_prefixed_packet_deframer_unit_assert.svh
// Assertion macros for the packet deframer.
// Used by length_prefixed_packet_deframer_unit; expects clk_i and rst_ni in scope.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Check a property at every edge outside of reset.
`define LPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define LPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/lpd_pkg.sv
// Constants and types of the packet deframer.
// No dependencies.
`default_nettype none

package lpd_pkg;

  localparam int BufferBytes = 64;
  localparam int StoreWords  = (BufferBytes + 1) / 2;
  localparam int CountW      = $clog2(BufferBytes + 1);
  localparam int AddrW       = $clog2(StoreWords);
  localparam int MaxPayload  = 30;
  localparam int LenW        = 7;
  localparam int IdxW        = 5;
  localparam int WordW       = 16;

  typedef logic [CountW-1:0] count_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [IdxW-1:0]   idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SHOW = 3'b100
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/length_prefixed_packet_deframer_unit.sv
// Packet deframer: packs bytes into 16-bit words, reports payload words on completion.
// Results: a header-only or overflow result shows in the cycle after its byte is accepted;
// a payload word goes through S_READ (word store read) and then S_SHOW.
// Throughput: 1 byte per cycle while no result is due; each payload word takes a store read
// (S_READ) and then output (S_SHOW), which holds until out_ready_i.
// Reset: count, header registers and control clear at once; no store clearing pass.
`default_nettype none
`include "length_prefixed_packet_deframer_unit_assert.svh"

module length_prefixed_packet_deframer_unit
  import lpd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         rx_valid_i,
  output logic              rx_ready_o,
  input  wire logic [7:0]   rx_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [LenW-1:0]   packet_length_o,
  output logic [WordW-1:0]  command_word_o,
  output logic [WordW-1:0]  data_word_o,
  output logic [IdxW-1:0]   word_index_o,
  output logic              has_data_o,
  output logic              last_o,
  output logic              status_o
);

  // Word store: payload lives here, written on every received byte as its word is assembled.
  word_t mem [StoreWords];

  state_e state_q, state_d;
  count_t count_q, count_d;
  word_t  word0_q, word0_d;   // declared length (word zero)
  word_t  cmd_q, cmd_d;       // command (word one)
  logic [7:0] hi_q, hi_d;     // high byte of the word being assembled
  idx_t   idx_q, idx_d;
  idx_t   pay_last_q, pay_last_d;
  logic [LenW-1:0] len_q, len_d;
  logic   has_data_q, has_data_d;
  logic   last_q, last_d;
  logic   status_q, status_d;
  word_t  rd_q;

  logic   accept;
  logic   ovf;
  logic   mem_we;
  addr_t  waddr;
  word_t  wdata;
  addr_t  raddr;
  logic   mem_re;
  count_t count_inc;
  count_t words;
  count_t pay;
  logic   complete;

  assign rx_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SHOW);
  assign accept      = rx_valid_i && rx_ready_o;
  assign ovf         = (count_q == count_t'(BufferBytes));

  // Even byte opens a fresh word with its low half cleared, odd byte fills the low half.
  assign mem_we    = accept && !ovf;
  assign waddr     = addr_t'(count_q >> 1);
  assign wdata     = count_q[0] ? {hi_q, rx_byte_i} : {rx_byte_i, 8'h00};
  assign count_inc = count_q + count_t'(1);

  // Payload word count, capped at the reportable maximum.
  assign words = count_t'((count_inc + count_t'(1)) >> 1);
  always_comb begin
    if (words > count_t'(2)) begin
      pay = words - count_t'(2);
    end else begin
      pay = '0;
    end
    if (pay > count_t'(MaxPayload)) begin
      pay = count_t'(MaxPayload);
    end
  end

  // Header words track the store's words zero and one.
  always_comb begin
    word0_d = word0_q;
    cmd_d   = cmd_q;
    if (mem_we) begin
      if (count_q == count_t'(0)) begin
        word0_d = {rx_byte_i, 8'h00};
      end else if (count_q == count_t'(1)) begin
        word0_d = {word0_q[15:8], rx_byte_i};
      end else if (count_q == count_t'(2)) begin
        cmd_d = {rx_byte_i, 8'h00};
      end else if (count_q == count_t'(3)) begin
        cmd_d = {cmd_q[15:8], rx_byte_i};
      end
    end
  end

  // Complete once the count meets the length latched from word zero.
  assign complete = (count_inc >= count_t'(2)) && (word_t'(count_inc) == word0_d);

  assign raddr  = addr_t'(idx_q) + addr_t'(2);
  assign mem_re = (state_q == S_READ);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    pay_last_d = pay_last_q;
    len_d      = len_q;
    has_data_d = has_data_q;
    last_d     = last_q;
    status_d   = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (ovf) begin
            // Drop the byte and report it.
            len_d      = '0;
            has_data_d = 1'b0;
            last_d     = 1'b0;
            status_d   = 1'b1;
            idx_d      = '0;
            state_d    = S_SHOW;
          end else begin
            count_d = count_inc;
            if (!count_q[0]) begin
              hi_d = rx_byte_i;
            end
            if (complete) begin
              count_d    = '0;
              len_d      = LenW'(count_inc);
              status_d   = 1'b0;
              idx_d      = '0;
              pay_last_d = idx_t'(pay - count_t'(1));
              if (pay == count_t'(0)) begin
                has_data_d = 1'b0;
                last_d     = 1'b1;
                state_d    = S_SHOW;
              end else begin
                has_data_d = 1'b1;
                state_d    = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        last_d  = (idx_q == pay_last_q);
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready_i) begin
          if (has_data_q && !last_q) begin
            idx_d   = idx_q + idx_t'(1);
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      word0_q    <= '0;
      cmd_q      <= '0;
      idx_q      <= '0;
      pay_last_q <= '0;
      has_data_q <= 1'b0;
      last_q     <= 1'b0;
      status_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      word0_q    <= word0_d;
      cmd_q      <= cmd_d;
      idx_q      <= idx_d;
      pay_last_q <= pay_last_d;
      has_data_q <= has_data_d;
      last_q     <= last_d;
      status_q   <= status_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    len_q <= len_d;
  end

  // Store port: write the assembled word, read the next payload word.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // Result fields: overflow items report zero everywhere but status.
  assign packet_length_o = len_q;
  assign command_word_o  = status_q ? '0 : cmd_q;
  assign data_word_o     = has_data_q ? rd_q : '0;
  assign word_index_o    = idx_q;
  assign has_data_o      = has_data_q;
  assign last_o          = last_q;
  assign status_o        = status_q;

  `LPD_ASSERT_ALWAYS(a_count_bound, (!rst_ni || count_q <= count_t'(BufferBytes)), "byte count past buffer")
  `LPD_ASSERT(a_no_overlap, !(rx_ready_o && out_valid_o), "input taken while result pending")
  `LPD_ASSERT(a_read_then_show, (state_q == S_READ) |=> (state_q == S_SHOW), "read not shown")
  `LPD_ASSERT(a_ovf_clean, (out_valid_o && status_o) |-> (!has_data_o && !last_o && len_q == '0), "overflow item carries data")
  `LPD_ASSERT(a_idx_bound, (has_data_q && state_q != S_IDLE) |-> (idx_q <= pay_last_q), "payload index past end")

endmodule

`default_nettype wire
